@@ src/tlmw_pkg.sv @@
// shared types, constants, microcode table and saturation helper for the tlm wave cell
package tlmw_pkg;

    localparam int DIRECTIONS = 6;
    localparam int PIDX_W     = (DIRECTIONS > 1) ? $clog2(DIRECTIONS) : 1;
    localparam int PCNT_W     = $clog2(DIRECTIONS + 1);
    localparam int STEP_W     = 4;

    // configuration register indexes
    localparam logic [2:0] REG_LOSS_COEFF     = 3'd0;
    localparam logic [2:0] REG_SPATIAL_COEFF  = 3'd1;
    localparam logic [2:0] REG_GROUND_COEFF   = 3'd2;
    localparam logic [2:0] REG_WAVE_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_SCATTER_DELAY  = 3'd4;
    localparam logic [2:0] REG_NEIGHBOR_MASK  = 3'd5;
    localparam logic [2:0] REG_REFLECT_MASK   = 3'd6;

    // configuration reset values
    localparam logic [17:0] LOSS_COEFF_RST     = 18'd65536;
    localparam logic [17:0] SPATIAL_COEFF_RST  = 18'd21845;
    localparam logic [17:0] GROUND_COEFF_RST   = 18'd65536;
    localparam logic [31:0] WAVE_THRESHOLD_RST = 32'd0;
    localparam logic [15:0] SCATTER_DELAY_RST  = 16'd1;
    localparam logic [5:0]  NEIGHBOR_MASK_RST  = 6'd63;
    localparam logic [5:0]  REFLECT_MASK_RST   = 6'd0;

    // event and result codes
    localparam logic FUNC_GATHER  = 1'b0;
    localparam logic FUNC_SCATTER = 1'b1;
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_PARTICLE = 1'b1;

    typedef enum logic [3:0] {
        U_FETCH,
        U_GATHER,
        U_MUL_LOSS,
        U_ADD_TOTAL,
        U_MUL_SPAT,
        U_SAT_SPAT,
        U_PORT_SUB,
        U_MUL_GND,
        U_TEST,
        U_CLEAR,
        U_FLUSH
    } uop_t;

    // step addresses of the program
    localparam logic [STEP_W-1:0] S_FETCH     = 4'd0;
    localparam logic [STEP_W-1:0] S_GATHER    = 4'd1;
    localparam logic [STEP_W-1:0] S_MUL_LOSS  = 4'd2;
    localparam logic [STEP_W-1:0] S_ADD_TOTAL = 4'd3;
    localparam logic [STEP_W-1:0] S_MUL_SPAT  = 4'd4;
    localparam logic [STEP_W-1:0] S_SAT_SPAT  = 4'd5;
    localparam logic [STEP_W-1:0] S_PORT_SUB  = 4'd6;
    localparam logic [STEP_W-1:0] S_MUL_GND   = 4'd7;
    localparam logic [STEP_W-1:0] S_TEST      = 4'd8;
    localparam logic [STEP_W-1:0] S_CLEAR     = 4'd9;
    localparam logic [STEP_W-1:0] S_FLUSH     = 4'd10;

    typedef struct packed {
        uop_t              op;
        logic [STEP_W-1:0] nxt;
        logic [STEP_W-1:0] alt;
    } ucw_t;

    // datapath feedback to the sequencer
    typedef struct packed {
        logic hold;
        logic take_alt;
    } seq_cond_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  dir;
        logic [31:0] disp;
        logic [15:0] wave_id;
        logic [31:0] due;
    } result_t;

    function automatic ucw_t ucode_rom(input logic [STEP_W-1:0] step);
        ucw_t w;
        case (step)
            S_FETCH:     w = '{op: U_FETCH,     nxt: S_GATHER,    alt: S_MUL_LOSS};
            S_GATHER:    w = '{op: U_GATHER,    nxt: S_FLUSH,     alt: S_FLUSH};
            S_MUL_LOSS:  w = '{op: U_MUL_LOSS,  nxt: S_ADD_TOTAL, alt: S_ADD_TOTAL};
            S_ADD_TOTAL: w = '{op: U_ADD_TOTAL, nxt: S_MUL_SPAT,  alt: S_MUL_SPAT};
            S_MUL_SPAT:  w = '{op: U_MUL_SPAT,  nxt: S_SAT_SPAT,  alt: S_SAT_SPAT};
            S_SAT_SPAT:  w = '{op: U_SAT_SPAT,  nxt: S_PORT_SUB,  alt: S_PORT_SUB};
            S_PORT_SUB:  w = '{op: U_PORT_SUB,  nxt: S_MUL_GND,   alt: S_CLEAR};
            S_MUL_GND:   w = '{op: U_MUL_GND,   nxt: S_TEST,      alt: S_TEST};
            S_TEST:      w = '{op: U_TEST,      nxt: S_PORT_SUB,  alt: S_PORT_SUB};
            S_CLEAR:     w = '{op: U_CLEAR,     nxt: S_FLUSH,     alt: S_FLUSH};
            S_FLUSH:     w = '{op: U_FLUSH,     nxt: S_FETCH,     alt: S_FETCH};
            default:     w = '{op: U_FETCH,     nxt: S_FETCH,     alt: S_FETCH};
        endcase
        return w;
    endfunction

    // clamp a 35-bit signed value to the q16.16 range
    function automatic logic [31:0] sat32(input logic [34:0] v);
        logic [31:0] r;
        if ((v[34:31] == 4'b0000) || (v[34:31] == 4'b1111)) begin
            r = v[31:0];
        end else if (v[34]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7fff_ffff;
        end
        return r;
    endfunction

endpackage

@@ src/tlm_wave_cell_update_unit.sv @@
// one tlm wave cell: gather/scatter update run by a microcoded sequencer
// results: a gather's request beat and a scatter's last beat are registered via the
//   pend and out registers, and the receiver can stall either
// throughput: one item at a time; the next beat is taken only after the last one
//   is flushed, and every multiply runs through the shared 32x18 multiplier
// reset: synchronous active-low aresetn clears state, ports and total, restores config
module tlm_wave_cell_update_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    // input events
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // direction, displacement, wave_id, event_time, zero pad
    input  logic        s_tuser,  // func
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,  // out_direction, out_displacement, out_wave_id, due_time, pad
    output logic        m_tuser,  // kind
    output logic        m_tlast   // last
);
    import tlmw_pkg::*;

    // configuration registers
    logic [17:0] loss_coeff_reg;
    logic [17:0] spatial_coeff_reg;
    logic [17:0] ground_coeff_reg;
    logic [31:0] wave_threshold_reg;
    logic [15:0] scatter_delay_reg;
    logic [5:0]  neighbor_mask_reg;
    logic [5:0]  reflect_mask_reg;

    // cell state
    logic [31:0] total_reg,  total_next;
    logic [31:0] port_reg  [DIRECTIONS];
    logic [31:0] port_next [DIRECTIONS];
    logic [31:0] nst_reg,    nst_next;   // next scatter time

    // latched event
    logic [2:0]  in_dir_reg,  in_dir_next;
    logic [31:0] in_disp_reg, in_disp_next;
    logic [15:0] in_id_reg,   in_id_next;
    logic [31:0] in_time_reg, in_time_next;

    // datapath working registers
    logic signed [50:0] prod_reg, prod_next;
    logic [31:0]        spat_reg, spat_next;   // spatial_coeff * total
    logic [31:0]        diff_reg, diff_next;
    logic [PCNT_W-1:0]  idx_reg,  idx_next;

    // one-deep lookahead so the final result can carry last
    result_t pend_reg, pend_next;
    logic    pend_valid_reg, pend_valid_next;

    // output register
    result_t out_reg, out_next;
    logic    out_last_reg, out_last_next;
    logic    out_valid_reg, out_valid_next;

    ucw_t      ucw;
    seq_cond_t cond;

    tlmw_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cond    (cond),
        .ucw     (ucw)
    );

    // shared multiplier: q16.16 signed times q2.16 unsigned
    logic [31:0]        mul_a;
    logic [17:0]        mul_c;
    logic signed [50:0] mul_p;
    logic [31:0]        qprod;

    always_comb begin
        case (ucw.op)
            U_MUL_LOSS: begin
                mul_a = in_disp_reg;
                mul_c = loss_coeff_reg;
            end
            U_MUL_SPAT: begin
                mul_a = total_reg;
                mul_c = spatial_coeff_reg;
            end
            default: begin
                mul_a = diff_reg;
                mul_c = ground_coeff_reg;
            end
        endcase
    end

    assign mul_p = $signed(mul_a) * $signed({1'b0, mul_c});
    // arithmetic shift by 16 floors toward minus infinity
    assign qprod = sat32(prod_reg[50:16]);

    // misc datapath terms
    logic [PIDX_W-1:0]     pidx;
    logic [DIRECTIONS-1:0] nb_mask;
    logic [DIRECTIONS-1:0] rf_mask;
    logic                  idx_done;
    logic [2:0]            opp;
    logic                  opp_ok;
    logic [31:0]           due;
    logic [32:0]           gsum;
    logic [32:0]           ssum;
    logic [32:0]           sdiff;
    logic [31:0]           cand;
    logic                  cand_hit;
    logic                  out_free;

    assign pidx     = idx_reg[PIDX_W-1:0];
    assign nb_mask  = neighbor_mask_reg[DIRECTIONS-1:0];
    assign rf_mask  = reflect_mask_reg[DIRECTIONS-1:0];
    assign idx_done = (idx_reg == PCNT_W'(DIRECTIONS));
    assign opp      = in_dir_reg ^ 3'd1;
    assign opp_ok   = (opp < 3'(DIRECTIONS));
    assign due      = in_time_reg + {16'd0, scatter_delay_reg};
    assign gsum     = {total_reg[31], total_reg} + {in_disp_reg[31], in_disp_reg};
    assign ssum     = {total_reg[31], total_reg} + {qprod[31], qprod};
    assign sdiff    = {spat_reg[31], spat_reg} - {port_reg[pidx][31], port_reg[pidx]};
    // reflecting ports take the product scaled by the ground coefficient, others the plain difference
    assign cand     = rf_mask[pidx] ? qprod : diff_reg;
    assign cand_hit = ($signed(cand) > $signed(wave_threshold_reg));
    assign out_free = !out_valid_reg || m_tready;

    // no beat is taken while reset is held
    assign s_tready = aresetn && (ucw.op == U_FETCH);

    // step execution
    always_comb begin
        total_next      = total_reg;
        port_next       = port_reg;
        nst_next        = nst_reg;
        in_dir_next     = in_dir_reg;
        in_disp_next    = in_disp_reg;
        in_id_next      = in_id_reg;
        in_time_next    = in_time_reg;
        prod_next       = prod_reg;
        spat_next       = spat_reg;
        diff_next       = diff_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        // output beat drains when taken
        out_valid_next  = out_valid_reg && !m_tready;
        cond            = '0;

        case (ucw.op)
            U_FETCH: begin
                if (s_tvalid) begin
                    in_dir_next   = s_tdata[2:0];
                    in_disp_next  = s_tdata[34:3];
                    in_id_next    = s_tdata[50:35];
                    in_time_next  = s_tdata[82:51];
                    cond.take_alt = (s_tuser == FUNC_SCATTER);
                end else begin
                    cond.hold = 1'b1;
                end
            end
            U_GATHER: begin
                // scatter request to self when the scheduled time has passed
                if (nst_reg < in_time_reg) begin
                    pend_next       = '{kind: KIND_REQUEST, dir: in_dir_reg, disp: 32'd0,
                                        wave_id: in_id_reg, due: due};
                    pend_valid_next = 1'b1;
                    nst_next        = due;
                end
                if (opp_ok) begin
                    port_next[opp[PIDX_W-1:0]] = in_disp_reg;
                end
                total_next = sat32({{2{gsum[32]}}, gsum});
            end
            U_MUL_LOSS: begin
                prod_next = mul_p;
            end
            U_ADD_TOTAL: begin
                total_next = sat32({{2{ssum[32]}}, ssum});
            end
            U_MUL_SPAT: begin
                prod_next = mul_p;
                idx_next  = '0;
            end
            U_SAT_SPAT: begin
                spat_next = qprod;
            end
            U_PORT_SUB: begin
                if (idx_done) begin
                    cond.take_alt = 1'b1;
                end else if (!nb_mask[pidx]) begin
                    // absent neighbor: skip the port in place
                    idx_next  = idx_reg + PCNT_W'(1);
                    cond.hold = 1'b1;
                end else begin
                    diff_next = sat32({{2{sdiff[32]}}, sdiff});
                end
            end
            U_MUL_GND: begin
                prod_next = mul_p;
            end
            U_TEST: begin
                if (cand_hit && pend_valid_reg && !out_free) begin
                    cond.hold = 1'b1;
                end else begin
                    if (cand_hit) begin
                        if (pend_valid_reg) begin
                            out_next       = pend_reg;
                            out_last_next  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        pend_next       = '{kind: KIND_PARTICLE, dir: 3'(pidx), disp: cand,
                                            wave_id: in_id_reg, due: in_time_reg};
                        pend_valid_next = 1'b1;
                    end
                    idx_next = idx_reg + PCNT_W'(1);
                end
            end
            U_CLEAR: begin
                total_next = '0;
                for (int i = 0; i < DIRECTIONS; i++) begin
                    port_next[i] = '0;
                end
            end
            U_FLUSH: begin
                // held result is the final one of this event
                if (pend_valid_reg) begin
                    if (out_free) begin
                        out_next        = pend_reg;
                        out_last_next   = 1'b1;
                        out_valid_next  = 1'b1;
                        pend_valid_next = 1'b0;
                    end else begin
                        cond.hold = 1'b1;
                    end
                end
            end
            default: begin
                cond = '0;
            end
        endcase
    end

    // control and cell state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg      <= '0;
            nst_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            for (int i = 0; i < DIRECTIONS; i++) begin
                port_reg[i] <= '0;
            end
        end else begin
            total_reg      <= total_next;
            nst_reg        <= nst_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            idx_reg        <= idx_next;
            port_reg       <= port_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        in_dir_reg   <= in_dir_next;
        in_disp_reg  <= in_disp_next;
        in_id_reg    <= in_id_next;
        in_time_reg  <= in_time_next;
        prod_reg     <= prod_next;
        spat_reg     <= spat_next;
        diff_reg     <= diff_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    // configuration writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loss_coeff_reg     <= LOSS_COEFF_RST;
            spatial_coeff_reg  <= SPATIAL_COEFF_RST;
            ground_coeff_reg   <= GROUND_COEFF_RST;
            wave_threshold_reg <= WAVE_THRESHOLD_RST;
            scatter_delay_reg  <= SCATTER_DELAY_RST;
            neighbor_mask_reg  <= NEIGHBOR_MASK_RST;
            reflect_mask_reg   <= REFLECT_MASK_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_LOSS_COEFF:     loss_coeff_reg     <= cfg_wdata[17:0];
                REG_SPATIAL_COEFF:  spatial_coeff_reg  <= cfg_wdata[17:0];
                REG_GROUND_COEFF:   ground_coeff_reg   <= cfg_wdata[17:0];
                REG_WAVE_THRESHOLD: wave_threshold_reg <= cfg_wdata;
                REG_SCATTER_DELAY:  scatter_delay_reg  <= cfg_wdata[15:0];
                REG_NEIGHBOR_MASK:  neighbor_mask_reg  <= cfg_wdata[5:0];
                REG_REFLECT_MASK:   reflect_mask_reg   <= cfg_wdata[5:0];
                default: begin
                end
            endcase
        end
    end

    // result channel
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'd0, out_reg.due, out_reg.wave_id, out_reg.disp, out_reg.dir};

endmodule

@@ src/tlmw_seq.sv @@
// microcode sequencer: step counter and control word fetch
module tlmw_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  tlmw_pkg::seq_cond_t cond,
    output tlmw_pkg::ucw_t      ucw
);
    import tlmw_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    assign ucw = ucode_rom(step_reg);

    always_comb begin
        if (cond.hold) begin
            step_next = step_reg;
        end else if (cond.take_alt) begin
            step_next = ucw.alt;
        end else begin
            step_next = ucw.nxt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= S_FETCH;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

@@ tb/tlm_cell_monitor.sv @@
// channel monitor for the tlm wave cell: predicts result beats and compares them
`timescale 1ns / 100ps

module tlm_cell_monitor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [87:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    input  logic        run_done,
    output int          fail_count,
    output int          outstanding,
    output int          events_seen,
    output int          scatters_seen,
    output int          requests_seen,
    output int          particles_seen
);
    import tlmw_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [2:0]  dir;
        logic [31:0] disp;
        logic [15:0] id;
        logic [31:0] due;
        logic        last;
    } cell_beat_t;

    localparam int REPORT_CAP = 40;

    // register copies
    logic [17:0] loss_q, spat_q, gnd_q;
    logic [31:0] thr_q;
    logic [15:0] delay_q;
    logic [5:0]  nbr_q, refl_q;

    // cell state copies
    logic [31:0] cell_total;
    logic [31:0] cell_port [0:DIRECTIONS-1];
    logic [31:0] next_due;

    cell_beat_t due_beats [$];
    bit         tail_checked = 1'b0;

    function automatic logic [31:0] clamp_q(input longint v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // q16.16 times unsigned q2.16, floor, saturate
    function automatic logic [31:0] scale_q(input logic [31:0] v, input logic [17:0] c);
        longint p;
        p = longint'($signed(v)) * longint'(c);
        return clamp_q(p >>> 16);
    endfunction

    function automatic logic [31:0] add_q(input logic [31:0] a, input logic [31:0] b);
        return clamp_q(longint'($signed(a)) + longint'($signed(b)));
    endfunction

    function automatic logic [31:0] sub_q(input logic [31:0] a, input logic [31:0] b);
        return clamp_q(longint'($signed(a)) - longint'($signed(b)));
    endfunction

    task automatic absorb_event(input logic func, input logic [2:0] dir,
                                input logic [31:0] disp, input logic [15:0] id,
                                input logic [31:0] now);
        cell_beat_t  made [0:DIRECTIONS];
        cell_beat_t  b;
        logic [31:0] scaled, d, due;
        logic [2:0]  opp;
        int          n, i;
        n = 0;
        if (func == FUNC_GATHER) begin
            opp = dir ^ 3'd1;
            if (next_due < now) begin
                due = now + {16'd0, delay_q};
                made[n] = '{kind: KIND_REQUEST, dir: dir, disp: 32'd0, id: id, due: due,
                            last: 1'b0};
                n++;
                next_due = due;
            end
            // write to an opposite port past the last direction is dropped
            if (int'(opp) < DIRECTIONS) cell_port[opp] = disp;
            cell_total = add_q(cell_total, disp);
        end else begin
            cell_total = add_q(cell_total, scale_q(disp, loss_q));
            scaled = scale_q(cell_total, spat_q);
            for (i = 0; i < DIRECTIONS; i++) begin
                if (nbr_q[i]) begin
                    d = sub_q(scaled, cell_port[i]);
                    if (refl_q[i]) d = scale_q(d, gnd_q);
                    if ($signed(d) > $signed(thr_q)) begin
                        made[n] = '{kind: KIND_PARTICLE, dir: 3'(i), disp: d, id: id,
                                    due: now, last: 1'b0};
                        n++;
                    end
                end
            end
            for (i = 0; i < DIRECTIONS; i++) cell_port[i] = 32'd0;
            cell_total = 32'd0;
        end
        for (i = 0; i < n; i++) begin
            b = made[i];
            b.last = (i == n - 1);
            due_beats.push_back(b);
        end
    endtask

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
                $display("%0t mismatch on %s: expected %h actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        cell_beat_t w;
        if (!aresetn) begin
            loss_q     = LOSS_COEFF_RST;
            spat_q     = SPATIAL_COEFF_RST;
            gnd_q      = GROUND_COEFF_RST;
            thr_q      = WAVE_THRESHOLD_RST;
            delay_q    = SCATTER_DELAY_RST;
            nbr_q      = NEIGHBOR_MASK_RST;
            refl_q     = REFLECT_MASK_RST;
            cell_total = 32'd0;
            next_due   = 32'd0;
            for (int i = 0; i < DIRECTIONS; i++) cell_port[i] = 32'd0;
            due_beats.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_LOSS_COEFF:     loss_q  = cfg_wdata[17:0];
                    REG_SPATIAL_COEFF:  spat_q  = cfg_wdata[17:0];
                    REG_GROUND_COEFF:   gnd_q   = cfg_wdata[17:0];
                    REG_WAVE_THRESHOLD: thr_q   = cfg_wdata;
                    REG_SCATTER_DELAY:  delay_q = cfg_wdata[15:0];
                    REG_NEIGHBOR_MASK:  nbr_q   = cfg_wdata[5:0];
                    REG_REFLECT_MASK:   refl_q  = cfg_wdata[5:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                absorb_event(s_tuser, s_tdata[2:0], s_tdata[34:3], s_tdata[50:35],
                             s_tdata[82:51]);
                events_seen++;
                if (s_tuser == FUNC_SCATTER) scatters_seen++;
            end
            if (m_tvalid && m_tready) begin
                if (due_beats.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP)
                        $display("%0t result beat with nothing expected: kind %0d data %h",
                                 $time, m_tuser, m_tdata);
                end else begin
                    w = due_beats.pop_front();
                    compare_field("kind", {31'd0, w.kind}, {31'd0, m_tuser});
                    compare_field("direction", {29'd0, w.dir}, {29'd0, m_tdata[2:0]});
                    compare_field("displacement", w.disp, m_tdata[34:3]);
                    compare_field("wave id", {16'd0, w.id}, {16'd0, m_tdata[50:35]});
                    compare_field("due time", w.due, m_tdata[82:51]);
                    compare_field("last", {31'd0, w.last}, {31'd0, m_tlast});
                    if (w.kind == KIND_REQUEST) requests_seen++;
                    else particles_seen++;
                end
            end
            if (run_done && !tail_checked) begin
                tail_checked = 1'b1;
                if (due_beats.size() != 0) begin
                    fail_count += due_beats.size();
                    $display("%0t %0d expected result beats never arrived", $time,
                             due_beats.size());
                end
            end
            outstanding = due_beats.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
// top of the tlm wave cell testbench: clock, reset, stimulus, receiver and verdict
`timescale 1ns / 100ps

module testbench;
    import tlmw_pkg::*;

    // cycles the block may still be busy after its last beat
    localparam int SETTLE_CYCLES = 40;
    // long receiver hold-off so the block backs up into its input
    localparam int HOLDOFF_CYCLES = 400;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_addr  = REG_LOSS_COEFF;
    logic [31:0] cfg_wdata = 32'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata   = 88'd0;
    logic        s_tuser   = FUNC_GATHER;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [87:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        run_done  = 1'b0;

    int fail_count, outstanding, events_seen, scatters_seen, requests_seen, particles_seen;

    // idling knobs, percent of cycles
    int idle_pct  = 0;
    int stall_pct = 0;

    // hold-off request: stimulus bumps the sequence, receiver counts the cycles
    int hold_seq  = 0;
    int hold_seen = 0;
    int hold_left = 0;

    // running simulation clock of the event stream
    logic [31:0] tick = 32'd0;
    int          settings_made = 0;

    tlm_wave_cell_update_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    tlm_cell_monitor monitor (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .run_done       (run_done),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .events_seen    (events_seen),
        .scatters_seen  (scatters_seen),
        .requests_seen  (requests_seen),
        .particles_seen (particles_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // receiver: random stalls, or a counted hold-off when asked
    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLDOFF_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // one input beat: random idle gap first, then hold valid until accepted
    task automatic send_item(input logic func, input logic [2:0] dir,
                             input logic [31:0] disp, input logic [15:0] id,
                             input logic [31:0] now);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        // tdata: direction, displacement, wave_id, event_time, zero pad
        s_tdata  <= {5'd0, now, id, disp, dir};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // stop sending and wait for every expected beat plus the tail of a silent gather
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // rewrite every register, only once the cell is idle
    task automatic set_cell(input logic [17:0] loss, input logic [17:0] spat,
                            input logic [17:0] gnd, input logic [31:0] thr,
                            input logic [15:0] dly, input logic [5:0] nbr,
                            input logic [5:0] refl);
        wait_drained();
        write_reg(REG_LOSS_COEFF, {14'd0, loss});
        write_reg(REG_SPATIAL_COEFF, {14'd0, spat});
        write_reg(REG_GROUND_COEFF, {14'd0, gnd});
        write_reg(REG_WAVE_THRESHOLD, thr);
        write_reg(REG_SCATTER_DELAY, {16'd0, dly});
        write_reg(REG_NEIGHBOR_MASK, {26'd0, nbr});
        write_reg(REG_REFLECT_MASK, {26'd0, refl});
        cfg_we <= 1'b0;
        settings_made++;
    endtask

    // random but mostly usable setting; long delays make requests rare
    task automatic shuffle_cell(input bit long_delay);
        logic [31:0] thr;
        case ($urandom_range(0, 3))
            0: thr = 32'd0;
            1: thr = -32'($urandom_range(0, 65536));
            2: thr = 32'($urandom_range(0, 4096));
            default: thr = $urandom;
        endcase
        set_cell(18'($urandom_range(0, 131072)), 18'($urandom_range(0, 65536)),
                 18'($urandom_range(0, 262143)), thr,
                 long_delay ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 8)),
                 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
    endtask

    // mix of rail values, full-range and small displacements
    function automatic logic [31:0] pick_disp();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        endcase
    endfunction

    // mostly small steps forward, sometimes a jump or a run up to the wrap
    task automatic advance_tick();
        case ($urandom_range(0, 19))
            0: tick = $urandom;
            1: tick = 32'hffff_fff0 + 32'($urandom_range(0, 15));
            default: tick = tick + 32'($urandom_range(0, 3));
        endcase
    endtask

    // well-formed runs of gathers closed by a scatter, with some raw noise
    task automatic run_waves(input int count);
        int          sent, g, k;
        logic [15:0] id;
        logic [2:0]  dir;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 15) begin
                send_item(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), $urandom,
                          16'($urandom), $urandom);
                sent++;
            end else begin
                id = 16'($urandom);
                g = $urandom_range(0, 6);
                for (k = 0; k < g; k++) begin
                    advance_tick();
                    // directions past the last port now and then
                    dir = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                     : 3'($urandom_range(0, 5));
                    send_item(FUNC_GATHER, dir, pick_disp(), id, tick);
                    sent++;
                end
                advance_tick();
                send_item(FUNC_SCATTER, 3'($urandom_range(0, 7)), pick_disp(), id, tick);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at reset settings, no idling
        send_item(FUNC_GATHER, 3'd0, 32'h0001_0000, 16'h0001, 32'd5);   // first request
        send_item(FUNC_GATHER, 3'd1, 32'hffff_ffff, 16'h0002, 32'd5);   // not past due
        send_item(FUNC_GATHER, 3'd2, 32'h7fff_ffff, 16'h0003, 32'd7);
        send_item(FUNC_GATHER, 3'd3, 32'h7fff_ffff, 16'h0004, 32'd7);   // total clamps high
        send_item(FUNC_GATHER, 3'd6, 32'h1234_5678, 16'h0005, 32'd9);   // port past the end
        send_item(FUNC_GATHER, 3'd7, 32'h8000_0000, 16'h0006, 32'd9);
        send_item(FUNC_SCATTER, 3'd0, 32'h8000_0000, 16'hffff, 32'd10);
        send_item(FUNC_GATHER, 3'd4, 32'h8000_0000, 16'h0007, 32'd0);
        send_item(FUNC_GATHER, 3'd5, 32'h8000_0000, 16'h0008, 32'd0);   // total clamps low
        send_item(FUNC_SCATTER, 3'd7, 32'h0000_0001, 16'h0000, 32'hffff_ffff);
        send_item(FUNC_GATHER, 3'd0, 32'h0000_0005, 16'h0009, 32'hffff_ffff); // due wraps
        send_item(FUNC_GATHER, 3'd2, 32'h0000_0007, 16'h000a, 32'hffff_ffff);
        send_item(FUNC_SCATTER, 3'd0, 32'h0000_0000, 16'h000b, 32'd20);
        send_item(FUNC_SCATTER, 3'd0, 32'h0000_0000, 16'h000c, 32'd21); // nothing emitted
        send_item(FUNC_GATHER, 3'd1, 32'h0000_0003, 16'h000d, 32'd30);
        send_item(FUNC_SCATTER, 3'd0, 32'hffff_fffd, 16'h000e, 32'd31); // floor on negatives
        send_item(FUNC_GATHER, 3'd5, 32'hffff_0000, 16'h000f, 32'd40);
        send_item(FUNC_SCATTER, 3'd3, 32'h0003_0000, 16'h0010, 32'd41);

        // top gains, ground zero on every port, lowest threshold: six beats a scatter
        set_cell(18'h3ffff, 18'h3ffff, 18'd0, 32'h8000_0000, 16'hffff, 6'h3f, 6'h3f);
        tick = 32'd0;
        run_waves(90);

        // sender idling; first a setting where no particle can get out
        idle_pct = 55;
        set_cell(18'd0, 18'd0, 18'h3ffff, 32'h7fff_ffff, 16'd0, 6'h00, 6'h00);
        run_waves(30);
        set_cell(18'd65536, 18'd21845, 18'h3ffff, 32'hffff_0000, 16'd0, 6'h2d, 6'h12);
        run_waves(60);

        // receiver stalling, fresh settings each round
        idle_pct = 0;
        stall_pct <= 55;
        repeat (4) begin
            shuffle_cell(1'b0);
            run_waves(30);
        end

        // both sides idling
        idle_pct = 23;
        stall_pct <= 23;
        repeat (4) begin
            shuffle_cell($urandom_range(0, 1));
            run_waves(30);
        end

        // back to reset values, receiver holds off while items keep coming
        idle_pct = 0;
        stall_pct <= 0;
        set_cell(LOSS_COEFF_RST, SPATIAL_COEFF_RST, GROUND_COEFF_RST, WAVE_THRESHOLD_RST,
                 SCATTER_DELAY_RST, NEIGHBOR_MASK_RST, REFLECT_MASK_RST);
        hold_seq <= hold_seq + 1;
        run_waves(60);

        wait_drained();
        run_done <= 1'b1;
        repeat (2) @(posedge aclk);

        $display("run covered %0d events (%0d scatters) over %0d register settings",
                 events_seen, scatters_seen, settings_made);
        $display("checked %0d request and %0d particle beats under idle, stall and hold-off",
                 requests_seen, particles_seen);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
